[rtl/core/assert_macros.svh]
// Assertion macros shared by the spline evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CRPS_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("crps assertion failed");
`define CRPS_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("crps forbidden condition seen");
`else
`define CRPS_ASSERT(lbl, ck, rs, prop)
`define CRPS_NEVER(lbl, ck, rs, cond)
`endif
`endif

[rtl/core/crps_pkg.sv]
`default_nettype none
package crps_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QW            = 32;
  localparam int DIV_LAT       = QW + 2;
  localparam int LERP_LAT      = 3;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] point_before;
    logic signed [31:0] start_point;
    logic signed [31:0] end_point;
    logic signed [31:0] point_after;
    logic signed [31:0] knot_before;
    logic signed [31:0] knot_start;
    logic signed [31:0] knot_end;
    logic signed [31:0] knot_after;
    logic signed [31:0] sample_time;
  } item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] slope;
    logic               degenerate;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } satq_t;

  function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    sub33 = $signed({a[31], a}) - $signed({b[31], b});
  endfunction

  function automatic satq_t add_sat(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
    logic [32:0] s;
    satq_t       r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      r.value = s[32] ? Q_MIN : Q_MAX;
      r.clip  = 1'b1;
    end else begin
      r.value = s[31:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/crps_dly.sv]
`default_nettype none
module crps_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[N-1];

endmodule
`default_nettype wire

[rtl/core/crps_div.sv]
`default_nettype none
// Pipelined restoring divider: num * 2^FRAC_BITS / den, rounded half away
// from zero, saturated to 32 bits. One quotient bit per stage.
module crps_div #(
  parameter int FRAC_BITS = crps_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] num,
  input  logic        [31:0] den,
  output logic signed [31:0] quo,
  output logic               clip
);

  localparam int QW = crps_pkg::QW;
  localparam int NW = 33 + FRAC_BITS;

  logic [31:0]    mag;
  logic [NW-1:0]  n_full;
  logic           ovf_in;

  logic [31:0]    rem   [0:QW];
  logic [QW-1:0]  low   [0:QW];
  logic [QW-1:0]  qbits [0:QW];
  logic [31:0]    dsor  [0:QW];
  logic           neg   [0:QW];
  logic           ovf   [0:QW];

  logic [QW-1:0]  q_fin;
  logic           clip_fin;

  assign mag    = num[32] ? 32'(-num) : num[31:0];
  assign n_full = (NW'(mag) << FRAC_BITS) + NW'(den >> 1);
  assign ovf_in = 32'(n_full[NW-1:QW]) >= den;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= 32'(n_full[NW-1:QW]);
      low[0]   <= n_full[QW-1:0];
      qbits[0] <= '0;
      dsor[0]  <= den;
      neg[0]   <= num[32];
      ovf[0]   <= ovf_in;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [32:0] trial;
    logic        ge;
    assign trial = {rem[i-1], low[i-1][QW-1]};
    assign ge    = trial >= {1'b0, dsor[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]   <= ge ? 32'(trial - {1'b0, dsor[i-1]}) : trial[31:0];
        low[i]   <= low[i-1] << 1;
        qbits[i] <= {qbits[i-1][QW-2:0], ge};
        dsor[i]  <= dsor[i-1];
        neg[i]   <= neg[i-1];
        ovf[i]   <= ovf[i-1];
      end
    end
  end

  assign q_fin    = qbits[QW];
  assign clip_fin = ovf[QW] || (!neg[QW] && q_fin[QW-1])
                 || (neg[QW] && q_fin[QW-1] && (|q_fin[QW-2:0]));

  always_ff @(posedge clk) begin
    if (en) begin
      clip <= clip_fin;
      if (clip_fin) begin
        quo <= neg[QW] ? crps_pkg::Q_MIN : crps_pkg::Q_MAX;
      end else begin
        quo <= neg[QW] ? $signed(~q_fin + 32'd1) : $signed(q_fin);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/crps_lerp.sv]
`default_nettype none
// y = x0 + round(w * (x1 - x0) / 2^FRAC_BITS), saturated; three stages.
module crps_lerp #(
  parameter int FRAC_BITS = crps_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] x0,
  input  logic signed [31:0] x1,
  input  logic signed [31:0] w,
  output logic signed [31:0] y,
  output logic               clip
);

  logic signed [32:0] diff;
  logic [31:0]        mw_1, mx_1;
  logic               neg_1, neg_2;
  logic signed [31:0] x0_1, x0_2;
  logic [63:0]        prod_2;
  logic [63:0]        rnd;
  logic signed [65:0] mag_s, sum;

  assign diff = crps_pkg::sub33(x1, x0);

  always_ff @(posedge clk) begin
    if (en) begin
      mw_1  <= w[31] ? (~w + 32'd1) : w;
      mx_1  <= diff[32] ? 32'(-diff) : diff[31:0];
      neg_1 <= w[31] ^ diff[32];
      x0_1  <= x0;
      prod_2 <= 64'(mw_1) * 64'(mx_1);
      neg_2  <= neg_1;
      x0_2   <= x0_1;
    end
  end

  assign rnd   = (prod_2 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign mag_s = $signed({2'b00, rnd});
  assign sum   = $signed({{34{x0_2[31]}}, x0_2}) + (neg_2 ? -mag_s : mag_s);

  always_ff @(posedge clk) begin
    if (en) begin
      if (sum > 66'sd2147483647) begin
        y    <= crps_pkg::Q_MAX;
        clip <= 1'b1;
      end else if (sum < -66'sd2147483648) begin
        y    <= crps_pkg::Q_MIN;
        clip <= 1'b1;
      end else begin
        y    <= sum[31:0];
        clip <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/catmull_rom_point_and_slope_top.sv]
`default_nettype none
// Non-uniform Catmull-Rom segment evaluator, one coordinate axis per word.
// Input channel item/item_valid/item_stall carries four control values, four
// knot times and the sample time; output channel result/result_valid/
// result_stall returns position, slope, a degenerate flag and a clip flag.
// Send three words for three axes.
// Throughput: one word per cycle while result_stall does not hold the output
// register. The depth comes from two chained restoring dividers (one
// quotient bit per stage) plus two blend stages, the slope sum register and
// the output register.
// Every stage advances together; while the output register holds a word
// that the receiver stalls, the whole pipeline freezes and item_stall is
// high, so nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty right after reset.
// A knot spacing that is zero or negative returns degenerate with zero
// position and slope.
module catmull_rom_point_and_slope_top #(
  parameter int FRAC_BITS = crps_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  crps_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output crps_pkg::result_t result
);

  localparam int DL    = crps_pkg::DIV_LAT;
  localparam int LL    = crps_pkg::LERP_LAT;
  localparam int T_A   = DL;
  localparam int T_B   = T_A + LL;
  localparam int T_C   = T_B + LL;
  localparam int T_PC  = T_C + LL;
  localparam int T_QB  = T_B + DL;
  localparam int T_DB  = T_QB + 1;
  localparam int T_QC  = T_C + DL;
  localparam int T_DC  = T_DB + LL;
  localparam int T_OUT = T_DC + 1;

  logic              adv;
  logic [T_OUT:0]    vld;
  crps_pkg::item_t   s0;

  logic signed [32:0] d10, d21, d32, d20, d31;
  logic               degen;

  logic signed [31:0] wa1, wa2, wa3, wb1, wb2, da1, da2, da3;
  logic               cw_a1, cw_a2, cw_a3, cw_b1, cw_b2, cd_1, cd_2, cd_3;
  logic signed [31:0] p0_a, p1_a, p2_a, p3_a;
  logic signed [31:0] a1, a2, a3, dl1, dl2;
  logic               ca1, ca2, ca3, cl1, cl2;
  logic signed [31:0] wb1_b, wb2_b, wa2_c, wa2_l;
  logic [31:0]        d20_b, d31_b, d21_b, d21_c;
  logic signed [31:0] b1, b2, c_pos, c_out;
  logic               cb1, cb2, cc;
  logic signed [31:0] qa, qb, qc, qc_d;
  logic               cqa, cqb, cqc;
  logic signed [31:0] dl1_q, dl2_q;
  logic signed [31:0] db1, db2, dlc;
  logic               cdl;
  logic               degen_out;
  crps_pkg::satq_t    s_db1, s_db2, s_dc;

  logic clip_a, clip_b, clip_c, clip_p, clip_q, clip_db, clip_qc, clip_dc;
  logic clip_b_d, clip_c_d, clip_p_d, clip_q_d, clip_qc_d, clip_dc_d;

  // Advance everything whenever the output slot is free or being taken.
  assign adv          = !result_valid || !result_stall;
  assign item_stall   = !adv;
  assign result_valid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[T_OUT-1:0], item_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0 <= item;
    end
  end

  assign d10   = crps_pkg::sub33(s0.knot_start, s0.knot_before);
  assign d21   = crps_pkg::sub33(s0.knot_end, s0.knot_start);
  assign d32   = crps_pkg::sub33(s0.knot_after, s0.knot_end);
  assign d20   = crps_pkg::sub33(s0.knot_end, s0.knot_before);
  assign d31   = crps_pkg::sub33(s0.knot_after, s0.knot_start);
  assign degen = d10[32] || d10 == '0 || d21[32] || d21 == '0
              || d32[32] || d32 == '0;

  // First level: all weights and control-point slopes.
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_wa1 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.sample_time, s0.knot_before)), .den(d10[31:0]),
    .quo(wa1), .clip(cw_a1));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_wa2 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.sample_time, s0.knot_start)), .den(d21[31:0]),
    .quo(wa2), .clip(cw_a2));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_wa3 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.sample_time, s0.knot_end)), .den(d32[31:0]),
    .quo(wa3), .clip(cw_a3));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_wb1 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.sample_time, s0.knot_before)), .den(d20[31:0]),
    .quo(wb1), .clip(cw_b1));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_wb2 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.sample_time, s0.knot_start)), .den(d31[31:0]),
    .quo(wb2), .clip(cw_b2));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_da1 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.start_point, s0.point_before)), .den(d10[31:0]),
    .quo(da1), .clip(cd_1));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_da2 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.end_point, s0.start_point)), .den(d21[31:0]),
    .quo(da2), .clip(cd_2));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_da3 (.clk, .en(adv),
    .num(crps_pkg::sub33(s0.point_after, s0.end_point)), .den(d32[31:0]),
    .quo(da3), .clip(cd_3));

  crps_dly #(.W(128), .N(T_A)) u_dly_pts (.clk, .en(adv),
    .d({s0.point_before, s0.start_point, s0.end_point, s0.point_after}),
    .q({p0_a, p1_a, p2_a, p3_a}));
  crps_dly #(.W(96), .N(T_B)) u_dly_den (.clk, .en(adv),
    .d({d20[31:0], d31[31:0], d21[31:0]}), .q({d20_b, d31_b, d21_b}));
  crps_dly #(.W(1), .N(T_DC)) u_dly_deg (.clk, .en(adv),
    .d(degen), .q(degen_out));

  assign clip_a = cw_a1 | cw_a2 | cw_a3 | cw_b1 | cw_b2 | cd_1 | cd_2 | cd_3;

  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_a1 (.clk, .en(adv),
    .x0(p0_a), .x1(p1_a), .w(wa1), .y(a1), .clip(ca1));
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_a2 (.clk, .en(adv),
    .x0(p1_a), .x1(p2_a), .w(wa2), .y(a2), .clip(ca2));
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_a3 (.clk, .en(adv),
    .x0(p2_a), .x1(p3_a), .w(wa3), .y(a3), .clip(ca3));
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_dl1 (.clk, .en(adv),
    .x0(da1), .x1(da2), .w(wb1), .y(dl1), .clip(cl1));
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_dl2 (.clk, .en(adv),
    .x0(da2), .x1(da3), .w(wb2), .y(dl2), .clip(cl2));

  crps_dly #(.W(64), .N(LL)) u_dly_wb (.clk, .en(adv),
    .d({wb1, wb2}), .q({wb1_b, wb2_b}));
  crps_dly #(.W(32), .N(T_C - T_A)) u_dly_wa2c (.clk, .en(adv),
    .d(wa2), .q(wa2_c));
  crps_dly #(.W(32), .N(T_DB - T_C)) u_dly_wa2l (.clk, .en(adv),
    .d(wa2_c), .q(wa2_l));
  crps_dly #(.W(1), .N(LL)) u_dly_ca (.clk, .en(adv),
    .d(clip_a), .q(clip_b_d));

  assign clip_b = clip_b_d | ca1 | ca2 | ca3 | cl1 | cl2;

  // Second level.
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_b1 (.clk, .en(adv),
    .x0(a1), .x1(a2), .w(wb1_b), .y(b1), .clip(cb1));
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_b2 (.clk, .en(adv),
    .x0(a2), .x1(a3), .w(wb2_b), .y(b2), .clip(cb2));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_qa (.clk, .en(adv),
    .num(crps_pkg::sub33(a2, a1)), .den(d20_b), .quo(qa), .clip(cqa));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_qb (.clk, .en(adv),
    .num(crps_pkg::sub33(a3, a2)), .den(d31_b), .quo(qb), .clip(cqb));
  crps_dly #(.W(64), .N(DL)) u_dly_dl (.clk, .en(adv),
    .d({dl1, dl2}), .q({dl1_q, dl2_q}));
  crps_dly #(.W(32), .N(LL)) u_dly_d21 (.clk, .en(adv),
    .d(d21_b), .q(d21_c));
  crps_dly #(.W(1), .N(LL)) u_dly_cb (.clk, .en(adv),
    .d(clip_b), .q(clip_c_d));

  assign clip_c = clip_c_d | cb1 | cb2;

  // Third level: position and the last quotient.
  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_c (.clk, .en(adv),
    .x0(b1), .x1(b2), .w(wa2_c), .y(c_pos), .clip(cc));
  crps_div #(.FRAC_BITS(FRAC_BITS)) u_div_qc (.clk, .en(adv),
    .num(crps_pkg::sub33(b2, b1)), .den(d21_c), .quo(qc), .clip(cqc));
  crps_dly #(.W(32), .N(T_DC - T_PC)) u_dly_pos (.clk, .en(adv),
    .d(c_pos), .q(c_out));
  crps_dly #(.W(1), .N(LL)) u_dly_cc (.clk, .en(adv),
    .d(clip_c), .q(clip_p_d));

  assign clip_p = clip_p_d | cc;

  crps_dly #(.W(1), .N(T_QB - T_PC)) u_dly_cp (.clk, .en(adv),
    .d(clip_p), .q(clip_q_d));

  assign clip_q = clip_q_d | cqa | cqb;
  assign s_db1  = crps_pkg::add_sat(qa, dl1_q);
  assign s_db2  = crps_pkg::add_sat(qb, dl2_q);

  always_ff @(posedge clk) begin
    if (adv) begin
      db1     <= s_db1.value;
      db2     <= s_db2.value;
      clip_db <= clip_q | s_db1.clip | s_db2.clip;
    end
  end

  crps_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_dc (.clk, .en(adv),
    .x0(db1), .x1(db2), .w(wa2_l), .y(dlc), .clip(cdl));
  crps_dly #(.W(32), .N(T_DC - T_QC)) u_dly_qc (.clk, .en(adv),
    .d(qc), .q(qc_d));
  crps_dly #(.W(1), .N(T_QC - T_DB)) u_dly_cdb (.clk, .en(adv),
    .d(clip_db), .q(clip_qc_d));

  assign clip_qc = clip_qc_d | cqc;

  crps_dly #(.W(1), .N(T_DC - T_QC)) u_dly_cqc (.clk, .en(adv),
    .d(clip_qc), .q(clip_dc_d));

  assign clip_dc = clip_dc_d | cdl;
  assign s_dc    = crps_pkg::add_sat(qc_d, dlc);

  // Output register; degenerate knots force zeros.
  always_ff @(posedge clk) begin
    if (adv) begin
      result.degenerate <= degen_out;
      if (degen_out) begin
        result.position  <= '0;
        result.slope     <= '0;
        result.saturated <= 1'b0;
      end else begin
        result.position  <= c_out;
        result.slope     <= s_dc.value;
        result.saturated <= clip_dc | s_dc.clip;
      end
    end
  end

  `include "assert_macros.svh"

  `CRPS_ASSERT(a_degen_zero, clk, rst, result_valid && result.degenerate |-> result.position == '0 && result.slope == '0)
  `CRPS_NEVER(a_degen_no_sat, clk, rst, result_valid && result.degenerate && result.saturated)
  `CRPS_ASSERT(a_stall_freezes, clk, rst, result_valid && result_stall |-> item_stall)
  `CRPS_ASSERT(a_empty_after_reset, clk, rst, $past(rst) |-> !result_valid)

endmodule
`default_nettype wire
